// ----- rtl/core/clbe_pkg.sv -----
// Shared types, codes and the character filter of the line edit buffer.
`timescale 1ns / 1ps

package clbe_pkg;

    // Key event and read opcodes.
    localparam logic [3:0] OP_CHAR  = 4'd0;
    localparam logic [3:0] OP_LEFT  = 4'd1;
    localparam logic [3:0] OP_RIGHT = 4'd2;
    localparam logic [3:0] OP_BACK  = 4'd3;
    localparam logic [3:0] OP_DEL   = 4'd4;
    localparam logic [3:0] OP_END   = 4'd5;
    localparam logic [3:0] OP_HOME  = 4'd6;
    localparam logic [3:0] OP_OTHER = 4'd7;
    localparam logic [3:0] OP_READ  = 4'd8;

    // Result status codes.
    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [6:0] CHAR_RUBOUT = 7'h7f;
    localparam logic [7:0] NAME_CTRL_U = 8'h55;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_SHIFT
    } t_cell_kind;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        t_cell_kind kind;
        logic [6:0] key;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_KILL
    } t_state;

    // Printable characters that a char key may insert.
    function automatic logic f_allowed(input logic [6:0] c);
        logic ok;
        case (c) inside
            [7'h61:7'h7a], [7'h41:7'h5a], [7'h30:7'h39],
            7'h20, 7'h2b, 7'h2d, 7'h2a, 7'h2f, 7'h5e, 7'h2e, 7'h5f, 7'h2c,
            7'h28, 7'h29, 7'h5b, 7'h5d, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25,
            7'h26, 7'h3d, 7'h7b, 7'h7d, 7'h7c, 7'h3f, 7'h3c, 7'h3e, 7'h60,
            7'h7e: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ----- rtl/core/clbe_cell.sv -----
// One character cell of the line buffer row.
`timescale 1ns / 1ps

module clbe_cell #(
    parameter int CELL_IDX = 0,
    parameter int PW       = 6
) (
    input  logic                 i_clk,
    input  clbe_pkg::t_cell_cmd  i_cmd,
    input  logic [PW-1:0]        i_pos,
    input  logic [6:0]           i_left_char,
    input  logic [6:0]           i_right_char,
    output logic [6:0]           o_char
);

    localparam logic [PW-1:0] MY_IDX = PW'(CELL_IDX);

    logic [6:0] r_char;
    logic [6:0] n_char;

    always_comb begin
        n_char = r_char;
        case (i_cmd.kind)
            clbe_pkg::CMD_INSERT: begin
                if (i_pos == MY_IDX) begin
                    n_char = i_cmd.key;
                end else if (i_pos < MY_IDX) begin
                    n_char = i_left_char;
                end
            end
            clbe_pkg::CMD_REMOVE: begin
                if (i_pos <= MY_IDX) begin
                    n_char = i_right_char;
                end
            end
            clbe_pkg::CMD_SHIFT: begin
                n_char = i_right_char;
            end
            default: begin
                n_char = r_char;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule

// ----- rtl/core/cursor_line_edit_buffer_top.sv -----
// Top level of the cursor line edit buffer: control, cursor state and the cell row.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  key in  | start / busy       | i_opcode i_key_char i_ctrl i_alt
//          |                    | i_name_second_char i_read_index
//  result  | o_valid (strobe)   | o_cursor o_line_length o_status o_read_char
//
// Every word is taken while busy is low; its result is registered for the next cycle.
// A Ctrl-U with the cursor away from the start keeps busy high while the cell
// row shifts left one place per cycle until the killed characters are gone;
// everything else leaves busy low. Synchronous active-low reset clears the
// cursor, the length and the controller; the cell contents are not reset. The
// result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps

module cursor_line_edit_buffer_top #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] i_opcode,
    input  logic [6:0] i_key_char,
    input  logic       i_ctrl,
    input  logic       i_alt,
    input  logic [7:0] i_name_second_char,
    input  logic [5:0] i_read_index,
    output logic       o_valid,
    output logic [6:0] o_cursor,
    output logic [6:0] o_line_length,
    output logic [1:0] o_status,
    output logic [6:0] o_read_char
);

    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int PW = $clog2(LINE_CAPACITY);
    localparam int XW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] CAP_C = CW'(LINE_CAPACITY);
    localparam logic [XW-1:0] CAP_X = XW'(LINE_CAPACITY);

    clbe_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_cur, n_cur;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_kill, n_kill;
    logic                r_valid, n_valid;
    logic [1:0]          r_status, n_status;
    logic [6:0]          r_rchar, n_rchar;

    clbe_pkg::t_cell_cmd w_cmd;
    logic [PW-1:0]       w_pos;
    logic [6:0]          w_chars [LINE_CAPACITY];

    logic                w_accept;
    logic                w_ctrl_u;
    logic [3:0]          w_op;
    logic [XW-1:0]       w_ridx;

    assign w_accept = start & (r_state == clbe_pkg::S_IDLE);
    assign w_ctrl_u = i_ctrl & ~i_alt & (i_name_second_char == clbe_pkg::NAME_CTRL_U);
    assign w_ridx   = XW'(i_read_index);

    // Ctrl without Alt, with rubout, turns a char key into a backspace.
    always_comb begin
        w_op = i_opcode;
        if (i_opcode == clbe_pkg::OP_CHAR && i_ctrl && !i_alt &&
            i_key_char == clbe_pkg::CHAR_RUBOUT) begin
            w_op = clbe_pkg::OP_BACK;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_cnt      = r_cnt;
        n_kill     = r_kill;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_rchar    = r_rchar;
        w_cmd.kind = clbe_pkg::CMD_HOLD;
        w_cmd.key  = i_key_char;
        w_pos      = PW'(r_cur);
        unique case (r_state)
            clbe_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_valid  = 1'b1;
                    n_rchar  = 7'd0;
                    n_status = clbe_pkg::ST_NOCHANGE;
                    if (i_opcode == clbe_pkg::OP_READ) begin
                        n_status = clbe_pkg::ST_APPLIED;
                        if (w_ridx < XW'(r_cnt) && w_ridx < CAP_X) begin
                            n_rchar = w_chars[PW'(i_read_index)];
                        end
                    end else if (w_ctrl_u) begin
                        n_cnt = r_cnt - r_cur;
                        n_cur = '0;
                        if (r_cur != '0) begin
                            n_status = clbe_pkg::ST_APPLIED;
                            n_kill   = r_cur;
                            n_state  = clbe_pkg::S_KILL;
                        end
                    end else begin
                        unique case (w_op)
                            clbe_pkg::OP_CHAR: begin
                                if (clbe_pkg::f_allowed(i_key_char)) begin
                                    if (r_cnt >= CAP_C) begin
                                        n_status = clbe_pkg::ST_FULL;
                                    end else begin
                                        w_cmd.kind = clbe_pkg::CMD_INSERT;
                                        n_cur      = r_cur + 1'b1;
                                        n_cnt      = r_cnt + 1'b1;
                                        n_status   = clbe_pkg::ST_APPLIED;
                                    end
                                end
                            end
                            clbe_pkg::OP_LEFT: begin
                                if (r_cur != '0) begin
                                    n_cur    = r_cur - 1'b1;
                                    n_status = clbe_pkg::ST_APPLIED;
                                end
                            end
                            clbe_pkg::OP_RIGHT: begin
                                if (r_cur < r_cnt) begin
                                    n_cur    = r_cur + 1'b1;
                                    n_status = clbe_pkg::ST_APPLIED;
                                end
                            end
                            clbe_pkg::OP_BACK: begin
                                if (r_cur != '0) begin
                                    w_cmd.kind = clbe_pkg::CMD_REMOVE;
                                    w_pos      = PW'(r_cur - 1'b1);
                                    n_cur      = r_cur - 1'b1;
                                    n_cnt      = r_cnt - 1'b1;
                                    n_status   = clbe_pkg::ST_APPLIED;
                                end
                            end
                            clbe_pkg::OP_DEL: begin
                                if (r_cur < r_cnt) begin
                                    w_cmd.kind = clbe_pkg::CMD_REMOVE;
                                    n_cnt      = r_cnt - 1'b1;
                                    n_status   = clbe_pkg::ST_APPLIED;
                                end
                            end
                            clbe_pkg::OP_END: begin
                                n_cur = r_cnt;
                                if (r_cur != r_cnt) begin
                                    n_status = clbe_pkg::ST_APPLIED;
                                end
                            end
                            clbe_pkg::OP_HOME: begin
                                n_cur = '0;
                                if (r_cur != '0) begin
                                    n_status = clbe_pkg::ST_APPLIED;
                                end
                            end
                            default: begin
                                n_status = clbe_pkg::ST_NOCHANGE;
                            end
                        endcase
                    end
                end
            end
            clbe_pkg::S_KILL: begin
                // The whole row moves one place left per cycle.
                w_cmd.kind = clbe_pkg::CMD_SHIFT;
                n_kill     = r_kill - 1'b1;
                if (r_kill == CW'(1)) begin
                    n_state = clbe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clbe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clbe_pkg::S_IDLE;
            r_cur   <= '0;
            r_cnt   <= '0;
            r_kill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_cnt   <= n_cnt;
            r_kill  <= n_kill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rchar  <= n_rchar;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LINE_CAPACITY; gi++) begin : g_cell
            logic [6:0] w_left;
            logic [6:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = 7'd0;
            end else begin : g_mid_l
                assign w_left = w_chars[gi-1];
            end
            if (gi == LINE_CAPACITY - 1) begin : g_last
                assign w_right = 7'd0;
            end else begin : g_mid_r
                assign w_right = w_chars[gi+1];
            end
            clbe_cell #(
                .CELL_IDX (gi),
                .PW       (PW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_pos        (w_pos),
                .i_left_char  (w_left),
                .i_right_char (w_right),
                .o_char       (w_chars[gi])
            );
        end
    endgenerate

    assign busy          = (r_state == clbe_pkg::S_KILL);
    assign o_valid       = r_valid;
    assign o_cursor      = 7'(r_cur);
    assign o_line_length = 7'(r_cnt);
    assign o_status      = r_status;
    assign o_read_char   = r_rchar;

endmodule

// ----- verif/cursor_line_edit_buffer_top_tb.sv -----
// Self-checking testbench for the cursor line edit buffer: key words in, edit results checked.
`timescale 1ns / 1ps

typedef struct {
    logic [6:0] cursor;
    logic [6:0] length;
    logic [1:0] status;
    logic [6:0] read_char;
} t_edit_result;

// Tracks the line contents and cursor, and holds the results still owed by the block.
class line_edit_tracker;
    int capacity;
    logic [6:0] cells[];
    int cur;
    int cnt;
    t_edit_result owed[$];
    int errors;
    int words;
    int results;
    int kills;
    int rejects;
    int reads;

    function new(int cap);
        capacity = cap;
        cells = new[cap];
        foreach (cells[i]) cells[i] = 7'd0;
        cur = 0;
        cnt = 0;
        errors = 0;
        words = 0;
        results = 0;
        kills = 0;
        rejects = 0;
        reads = 0;
    endfunction

    function int pending();
        return owed.size();
    endfunction

    function int length();
        return cnt;
    endfunction

    function bit printable(logic [6:0] c);
        string marks = " +-*/^._,()[]!@#$%&={}|?<>~";
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
            return 1'b1;
        // The backtick is kept out of the string and matched by its code.
        if (c == 7'h60)
            return 1'b1;
        for (int i = 0; i < marks.len(); i++)
            if (marks[i] == {1'b0, c})
                return 1'b1;
        return 1'b0;
    endfunction

    function void drop_cell(int pos);
        for (int i = pos; i < cnt - 1; i++)
            cells[i] = cells[i + 1];
        cnt--;
    endfunction

    function void note_word(logic [3:0] op, logic [6:0] key, logic ctrl, logic alt,
                            logic [7:0] name2, logic [5:0] ridx);
        int old_cur;
        int old_cnt;
        int keep;
        logic [3:0] act;
        logic [1:0] st;
        logic [6:0] rch;
        t_edit_result res;
        old_cur = cur;
        old_cnt = cnt;
        st = clbe_pkg::ST_NOCHANGE;
        rch = 7'd0;
        act = op;
        words++;
        if (op == clbe_pkg::OP_READ) begin
            if (ridx < cnt)
                rch = cells[ridx];
            st = clbe_pkg::ST_APPLIED;
            reads++;
        end else if (ctrl && !alt && name2 == clbe_pkg::NAME_CTRL_U) begin
            // Kill to start of line: the tail moves down to position zero.
            keep = cnt - cur;
            for (int i = 0; i < keep; i++)
                cells[i] = cells[cur + i];
            if (cur > 0)
                kills++;
            cnt = keep;
            cur = 0;
        end else begin
            if (op == clbe_pkg::OP_CHAR && ctrl && !alt && key == clbe_pkg::CHAR_RUBOUT)
                act = clbe_pkg::OP_BACK;
            case (act)
                clbe_pkg::OP_CHAR: begin
                    if (printable(key)) begin
                        if (cnt >= capacity) begin
                            st = clbe_pkg::ST_FULL;
                            rejects++;
                        end else begin
                            for (int i = cnt; i > cur; i--)
                                cells[i] = cells[i - 1];
                            cells[cur] = key;
                            cnt++;
                            cur++;
                        end
                    end
                end
                clbe_pkg::OP_LEFT: if (cur > 0) cur--;
                clbe_pkg::OP_RIGHT: if (cur < cnt) cur++;
                clbe_pkg::OP_BACK: begin
                    if (cur > 0) begin
                        drop_cell(cur - 1);
                        cur--;
                    end
                end
                clbe_pkg::OP_DEL: if (cur < cnt) drop_cell(cur);
                clbe_pkg::OP_END: cur = cnt;
                clbe_pkg::OP_HOME: cur = 0;
                default: ;
            endcase
        end
        if (op != clbe_pkg::OP_READ && st != clbe_pkg::ST_FULL)
            st = (cur != old_cur || cnt != old_cnt) ? clbe_pkg::ST_APPLIED
                                                    : clbe_pkg::ST_NOCHANGE;
        res.cursor = cur[6:0];
        res.length = cnt[6:0];
        res.status = st;
        res.read_char = rch;
        owed.push_back(res);
    endfunction

    function void cmp_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [6:0] cursor, logic [6:0] len, logic [1:0] status,
                               logic [6:0] rch);
        t_edit_result want;
        results++;
        if (owed.size() == 0) begin
            $display("%0t: result with nothing expected, cursor %0d length %0d status %0d",
                     $time, cursor, len, status);
            errors++;
            return;
        end
        want = owed.pop_front();
        cmp_field("cursor", want.cursor, cursor);
        cmp_field("line_length", want.length, len);
        cmp_field("status", {5'd0, want.status}, {5'd0, status});
        cmp_field("read_char", want.read_char, rch);
    endfunction
endclass

module cursor_line_edit_buffer_top_tb;

    localparam int LINE_CAPACITY  = 64;
    localparam int RANDOM_WORDS   = 1400;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct {
        logic [3:0] op;
        logic [6:0] key;
        logic       ctrl;
        logic       alt;
        logic [7:0] name2;
        logic [5:0] ridx;
    } t_key_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [3:0] i_opcode = 4'd0;
    logic [6:0] i_key_char = 7'd0;
    logic       i_ctrl = 1'b0;
    logic       i_alt = 1'b0;
    logic [7:0] i_name_second_char = 8'd0;
    logic [5:0] i_read_index = 6'd0;
    logic       o_valid;
    logic [6:0] o_cursor;
    logic [6:0] o_line_length;
    logic [1:0] o_status;
    logic [6:0] o_read_char;

    line_edit_tracker sb = new(LINE_CAPACITY);
    int cycles = 0;
    int burst_left = 0;
    int bias = 90;
    int phase_left = 0;

    cursor_line_edit_buffer_top #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_key_char(i_key_char),
        .i_ctrl(i_ctrl),
        .i_alt(i_alt),
        .i_name_second_char(i_name_second_char),
        .i_read_index(i_read_index),
        .o_valid(o_valid),
        .o_cursor(o_cursor),
        .o_line_length(o_line_length),
        .o_status(o_status),
        .o_read_char(o_read_char)
    );

    always #5 i_clk = ~i_clk;

    // Accepted words and result strobes are both seen at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_word(i_opcode, i_key_char, i_ctrl, i_alt, i_name_second_char,
                             i_read_index);
            if (o_valid)
                sb.check_result(o_cursor, o_line_length, o_status, o_read_char);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("%0t: run exceeded %0d cycles", $time, TIMEOUT_CYCLES);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_word(t_key_word w);
        i_opcode <= w.op;
        i_key_char <= w.key;
        i_ctrl <= w.ctrl;
        i_alt <= w.alt;
        i_name_second_char <= w.name2;
        i_read_index <= w.ridx;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Bursts of random length, separated by random gaps or by none.
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    function automatic t_key_word mk(logic [3:0] op, logic [6:0] key, logic ctrl,
                                     logic alt, logic [7:0] name2, logic [5:0] ridx);
        t_key_word w;
        w.op = op;
        w.key = key;
        w.ctrl = ctrl;
        w.alt = alt;
        w.name2 = name2;
        w.ridx = ridx;
        return w;
    endfunction

    function automatic logic [6:0] pick_printable();
        logic [6:0] c;
        do c = 7'($urandom_range(0, 127)); while (!sb.printable(c));
        return c;
    endfunction

    function automatic t_key_word random_word();
        t_key_word w;
        int len;
        w = mk(4'($urandom), 7'($urandom), ($urandom_range(0, 3) == 0),
               ($urandom_range(0, 3) == 0), 8'($urandom), 6'($urandom));
        len = sb.length();
        if ($urandom_range(0, 99) < bias) begin
            w.op = clbe_pkg::OP_CHAR;
            w.key = pick_printable();
            w.ctrl = ($urandom_range(0, 7) == 0);
            w.alt = ($urandom_range(0, 7) == 0);
        end else begin
            case ($urandom_range(0, 13))
                0, 13: w.op = clbe_pkg::OP_LEFT;
                1: w.op = clbe_pkg::OP_RIGHT;
                2: w.op = clbe_pkg::OP_BACK;
                3: w.op = clbe_pkg::OP_DEL;
                4: w.op = clbe_pkg::OP_END;
                5: w.op = clbe_pkg::OP_HOME;
                6: w.op = clbe_pkg::OP_OTHER;
                7: begin
                    w.op = clbe_pkg::OP_READ;
                    if (len > 0 && $urandom_range(0, 3) != 0)
                        w.ridx = 6'($urandom_range(0, len - 1));
                end
                8: w.op = 4'($urandom_range(9, 15));
                9: begin
                    // Kill to start of line on any opcode but a read.
                    do w.op = 4'($urandom); while (w.op == clbe_pkg::OP_READ);
                    w.ctrl = 1'b1;
                    w.alt = 1'b0;
                    w.name2 = clbe_pkg::NAME_CTRL_U;
                end
                10: begin
                    w.op = clbe_pkg::OP_CHAR;
                    w.key = clbe_pkg::CHAR_RUBOUT;
                    w.ctrl = 1'b1;
                    w.alt = ($urandom_range(0, 3) == 0);
                end
                11: w.op = clbe_pkg::OP_CHAR;
                default: w.op = clbe_pkg::OP_READ;
            endcase
        end
        return w;
    endfunction

    initial begin
        t_key_word plan[$];
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(mk(clbe_pkg::OP_LEFT, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_BACK, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_DEL, 7'h7f, 1'b0, 1'b0, 8'hff, 6'd63));
        plan.push_back(mk(clbe_pkg::OP_READ, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h61, 1'b1, 1'b0, clbe_pkg::NAME_CTRL_U, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h61, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h5a, 1'b1, 1'b1, 8'h41, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h60, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h7e, 1'b0, 1'b1, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h00, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h7f, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h7f, 1'b1, 1'b1, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h7f, 1'b1, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_HOME, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_LEFT, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_CHAR, 7'h30, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_END, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_RIGHT, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_LEFT, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_DEL, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_READ, 7'd0, 1'b1, 1'b0, clbe_pkg::NAME_CTRL_U, 6'd1));
        plan.push_back(mk(clbe_pkg::OP_READ, 7'd0, 1'b0, 1'b0, 8'd0, 6'd63));
        plan.push_back(mk(clbe_pkg::OP_OTHER, 7'h41, 1'b1, 1'b1, 8'd0, 6'd0));
        plan.push_back(mk(4'hf, 7'h7f, 1'b1, 1'b1, 8'hff, 6'd63));
        plan.push_back(mk(clbe_pkg::OP_HOME, 7'd0, 1'b1, 1'b1, clbe_pkg::NAME_CTRL_U, 6'd0));
        plan.push_back(mk(clbe_pkg::OP_END, 7'd0, 1'b0, 1'b0, 8'd0, 6'd0));
        plan.push_back(mk(4'hf, 7'd0, 1'b1, 1'b0, clbe_pkg::NAME_CTRL_U, 6'd0));
        foreach (plan[i]) begin
            send_word(plan[i]);
            pace();
        end
        drain();

        // Random phases lean toward typing, mixed editing or cursor work.
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (phase_left <= 0) begin
                case ($urandom_range(0, 2))
                    0: bias = 92;
                    1: bias = 65;
                    default: bias = 35;
                endcase
                phase_left = $urandom_range(60, 140);
                if ($urandom_range(0, 2) == 0)
                    drain();
            end
            send_word(random_word());
            phase_left--;
            pace();
        end

        start <= 1'b0;
        n = 0;
        do begin
            @(posedge i_clk);
            n++;
        end while (sb.pending() > 0 && n < 300);
        repeat (4) @(posedge i_clk);
        if (sb.pending() > 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors += sb.pending();
        end

        $display("run covered %0d key words and %0d results, with %0d line kills,",
                 sb.words, sb.results, sb.kills);
        $display("%0d inserts rejected on a full line and %0d character reads",
                 sb.rejects, sb.reads);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
